### hw/rtl/trie_pkg.sv
// ----------------------------------------------------------------------------
// trie_pkg
// Shared types and constants for the trie word insert block.
// ----------------------------------------------------------------------------
package trie_pkg;

  localparam int unsigned LetterW  = 8;
  localparam int unsigned NodeOutW = 12;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 16;

  localparam logic [LetterW-1:0] LetterBase = 8'd97;  // 'a'
  localparam logic [CountW-1:0]  CountMax   = 16'hFFFF;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;
  localparam logic [StatusW-1:0] STATUS_SKIP = 2'd3;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               word_end;
  } in_item_t;

  typedef struct packed {
    logic [NodeOutW-1:0] node_reached;
    logic                node_created;
    logic [StatusW-1:0]  status;
    logic                word_done;
    logic [CountW-1:0]   words_added;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;   // clearing pass, one store entry per cycle
    logic load;     // request accepted: latch it and read the link
    logic commit;   // evaluate, update state, load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/trie_in_if.sv
// ----------------------------------------------------------------------------
// trie_in_if
// Request channel: one character per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trie_in_if;
  logic              valid;
  logic              ready;
  trie_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/trie_out_if.sv
// ----------------------------------------------------------------------------
// trie_out_if
// Result channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trie_out_if;
  logic               valid;
  logic               ready;
  trie_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/trie_ctrl.sv
// ----------------------------------------------------------------------------
// trie_ctrl
// Sequencer: clearing pass after reset, then accept / evaluate per request.
// ----------------------------------------------------------------------------
module trie_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  trie_pkg::dp_stat_t stat_i,
  output trie_pkg::dp_cmd_t  cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/trie_dp.sv
// ----------------------------------------------------------------------------
// trie_dp
// Datapath: link store, word end marks, walk state, output register.
// ----------------------------------------------------------------------------
module trie_dp #(
  parameter int unsigned MAX_NODES     = 4096,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trie_pkg::dp_cmd_t   cmd_i,
  output trie_pkg::dp_stat_t  stat_o,
  input  trie_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output trie_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth  = MAX_NODES * ALPHABET_SIZE;
  localparam int unsigned NodeW  = $clog2(MAX_NODES);
  localparam int unsigned FreeW  = $clog2(MAX_NODES + 1);
  localparam int unsigned IdxW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned AddrW  = $clog2(Depth);

  // link store: node index of the child, zero means no child
  logic [NodeW-1:0] link_mem [Depth];
  logic             mark_mem [MAX_NODES];

  logic [AddrW-1:0] clr_cnt_q;
  logic [FreeW-1:0] free_q, free_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic             skip_q, skip_d;
  logic [trie_pkg::CountW-1:0] count_q, count_d;
  logic             out_valid_q;

  logic [AddrW-1:0] addr_q;
  logic             last_q;
  logic             bad_q;
  logic [NodeW-1:0] link_q;
  trie_pkg::out_item_t out_q, out_d;

  logic [trie_pkg::LetterW-1:0] diff;
  logic             bad_char;
  logic [IdxW-1:0]  idx;
  logic [AddrW-1:0] rd_addr;

  logic             missing, full, ok;
  logic [NodeW-1:0] next_node;
  logic             link_we;
  logic             mark_we;

  // ---- request side: letter check and link address ----
  assign diff     = in_item_i.letter - trie_pkg::LetterBase;
  assign bad_char = (in_item_i.letter < trie_pkg::LetterBase) ||
                    (diff >= trie_pkg::LetterW'(ALPHABET_SIZE));
  assign idx      = IdxW'(diff);
  assign rd_addr  = AddrW'(cur_q) * AddrW'(ALPHABET_SIZE) + AddrW'(idx);

  // ---- evaluate ----
  assign missing   = (link_q == '0);
  assign full      = (free_q >= FreeW'(MAX_NODES));
  assign ok        = !skip_q && !bad_q && !(missing && full);
  assign next_node = missing ? free_q[NodeW-1:0] : link_q;
  assign link_we   = cmd_i.commit && ok && missing;
  assign mark_we   = cmd_i.commit && ok && last_q;

  always_comb begin
    free_d  = free_q;
    cur_d   = cur_q;
    skip_d  = skip_q;
    count_d = count_q;
    out_d   = '0;
    out_d.words_added = count_q;
    if (skip_q) begin
      skip_d       = !last_q;
      cur_d        = '0;
      out_d.status = trie_pkg::STATUS_SKIP;
    end else if (bad_q || (missing && full)) begin
      skip_d       = !last_q;
      cur_d        = '0;
      out_d.status = bad_q ? trie_pkg::STATUS_BAD : trie_pkg::STATUS_FULL;
    end else begin
      out_d.status       = trie_pkg::STATUS_OK;
      out_d.node_reached = trie_pkg::NodeOutW'(next_node);
      out_d.node_created = missing;
      if (missing) free_d = free_q + FreeW'(1);
      if (last_q) begin
        cur_d           = '0;
        out_d.word_done = 1'b1;
        if (count_q != trie_pkg::CountMax) count_d = count_q + 16'd1;
        out_d.words_added = count_d;
      end else begin
        cur_d = next_node;
      end
    end
  end

  // ---- memories ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      link_mem[clr_cnt_q] <= '0;
    end else if (link_we) begin
      link_mem[addr_q] <= free_q[NodeW-1:0];
    end
    if (cmd_i.load) link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en && (clr_cnt_q < AddrW'(MAX_NODES))) begin
      mark_mem[clr_cnt_q[NodeW-1:0]] <= 1'b0;
    end else if (mark_we) begin
      mark_mem[next_node] <= 1'b1;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= rd_addr;
      last_q <= in_item_i.word_end;
      bad_q  <= bad_char;
    end
    if (cmd_i.commit) out_q <= out_d;
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      free_q      <= FreeW'(1);
      cur_q       <= '0;
      skip_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (cmd_i.commit) begin
        free_q  <= free_d;
        cur_q   <= cur_d;
        skip_q  <= skip_d;
        count_q <= count_d;
      end
      if (cmd_i.commit)    out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.clr_done = (clr_cnt_q == AddrW'(Depth - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule

### hw/rtl/trie_word_insert_top.sv
// ----------------------------------------------------------------------------
// trie_word_insert_top
// Inserts words, one character per request, into a 26-way trie node store.
// ----------------------------------------------------------------------------
// After reset the block clears its link store, one entry per cycle, until all
// MAX_NODES*ALPHABET_SIZE entries are zero; requests are held off until then.
// For each request the accept cycle reads the child link from the single-port
// link store; the evaluate state then evaluates it, writes a new link if one
// is missing and loads the output register. A result still waiting in the
// output register delays the evaluate step and so also the accept of the next
// request. Every request gives exactly one result.
module trie_word_insert_top #(
  parameter int unsigned MAX_NODES     = 4096,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic clk_i,
  input  logic rst_ni,
  trie_in_if.sink    in_i,
  trie_out_if.source out_o
);

  trie_pkg::dp_cmd_t  cmd;
  trie_pkg::dp_stat_t stat;

  trie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  trie_dp #(
    .MAX_NODES     (MAX_NODES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_i.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.payload)
  );

endmodule

### hw/rtl/trie_checker.sv
// ----------------------------------------------------------------------------
// trie_checker
// Port-level assertions for trie_word_insert_top, attached by bind.
// ----------------------------------------------------------------------------
module trie_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input trie_pkg::out_item_t out_item_i
);

  // result must stay offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while previous one is in evaluation");

  // error and skip results carry no node and no word
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status != trie_pkg::STATUS_OK) |->
      (out_item_i.node_reached == '0) && !out_item_i.node_created &&
      !out_item_i.word_done)
    else $error("error result carries node data");

  // a finished word has been counted
  a_done_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.word_done |->
      (out_item_i.words_added != '0) && (out_item_i.node_reached != '0))
    else $error("word done without count or node");

endmodule

bind trie_word_insert_top trie_checker u_trie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
